@@ hdl/clst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clst_pkg - shared types and tables for the C-like source tokenizer
// Token record, scanner modes, character codes, keyword table and the small
// character classifiers used by the scanner.
// ----------------------------------------------------------------------------
package clst_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int KEYWORD_COUNT     = 26;
  localparam int WORD_DEPTH        = 9;
  localparam int KW_IDX_W          = 5;
  localparam int WORD_LEN_W        = 4;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_IDENT     = 3'd1,
    MODE_INT       = 3'd2,
    MODE_SLASH     = 3'd3,
    MODE_COMMENT   = 3'd4,
    MODE_DIRECTIVE = 3'd5,
    MODE_REL       = 3'd6,
    MODE_STRING    = 3'd7
  } scan_mode_t;

  typedef enum logic [3:0] {
    CLS_KEYWORD  = 4'd0,
    CLS_IDENT    = 4'd1,
    CLS_INTEGER  = 4'd2,
    CLS_OPERATOR = 4'd3,
    CLS_SYMBOL   = 4'd4,
    CLS_DIRECT   = 4'd5,
    CLS_REL      = 4'd6,
    CLS_STRING   = 4'd7,
    CLS_UNKNOWN  = 4'd8,
    CLS_END      = 4'd9
  } tok_class_t;

  typedef struct packed {
    tok_class_t          cls;
    logic [KW_IDX_W-1:0] kw;
    logic [15:0]         start;
    logic [15:0]         len;
    logic [7:0]          c1;
    logic [7:0]          c2;
    logic                last;
  } tok_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keyword text, right-justified: the last character sits in the low byte.
  localparam logic [8*WORD_DEPTH-1:0] KW_TEXT [KEYWORD_COUNT] = '{
    "int", "double", "float", "for", "while", "if", "else", "char", "bool",
    "break", "return", "private", "public", "protected", "new", "class",
    "struct", "true", "false", "switch", "case", "continue", "default",
    "virtual", "void", "enum"
  };

  localparam logic [WORD_LEN_W-1:0] KW_LEN [KEYWORD_COUNT] = '{
    4'd3, 4'd6, 4'd5, 4'd3, 4'd5, 4'd2, 4'd4, 4'd4, 4'd4,
    4'd5, 4'd6, 4'd7, 4'd6, 4'd9, 4'd3, 4'd5,
    4'd6, 4'd4, 4'd5, 4'd6, 4'd4, 4'd8, 4'd7,
    4'd7, 4'd4, 4'd4
  };

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic rel_pair(input logic [7:0] a, input logic [7:0] b);
    logic ok;
    ok = 1'b0;
    case (a)
      CH_EQ, CH_BANG: ok = (b == CH_EQ);
      CH_LT:          ok = (b == CH_LT) || (b == CH_EQ);
      CH_GT:          ok = (b == CH_GT) || (b == CH_EQ);
      CH_BAR:         ok = (b == CH_BAR);
      default:        ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic tok_t make_tok(input tok_class_t cls,
                                    input logic [KW_IDX_W-1:0] kw,
                                    input logic [15:0] start,
                                    input logic [15:0] len,
                                    input logic [7:0] c1,
                                    input logic [7:0] c2);
    tok_t t;
    t.cls   = cls;
    t.kw    = kw;
    t.start = start;
    t.len   = len;
    t.c1    = c1;
    t.c2    = c2;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

@@ hdl/c_like_source_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_like_source_tokenizer - streaming lexer for C-like source text
// Takes source text one byte per beat and emits a token beat whenever a
// token completes: keywords, identifiers, integers, operators, symbols,
// directives, relationals, strings, unidentified bytes and an end token.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Data                                   | Side bands
//  ---------+-----+----------------------------------------+--------------------
//  s_axis   | in  | s_tdata: text_byte                     | s_tlast: end_of_input
//  m_axis   | out | m_tdata: keyword_index, start_position,| m_tuser: token_class
//           |     |   token_length, lead_char, second_char | m_tlast: last_of_run
//
//  One input beat per cycle; each beat yields zero, one or two tokens.
//  Tokens are registered in a four-entry token queue and leave it one per
//  cycle while m_tready is high; s_tready drops while the queue has fewer
//  than two free slots, so a byte run that makes two tokens per beat runs at
//  the output rate of one token per cycle.
//  Synchronous active-high reset clears the scanner and empties the queue;
//  no clearing pass is needed. An end-of-input beat returns the scanner to
//  offset 0 by itself.
// ----------------------------------------------------------------------------
module c_like_source_tokenizer #(
  parameter int POSITION_BITS = clst_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_input
  // token stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [4:0] keyword_index, [20:5] start_position,
                                 // [36:21] token_length, [44:37] lead_char,
                                 // [52:45] second_char, [55:53] zero
  output logic [3:0]  m_tuser,   // [3:0] token_class
  output logic        m_tlast    // last_of_run
);
  import clst_pkg::*;

  logic       step;
  logic       room2;
  logic [1:0] wr_n;
  tok_t       tok0, tok1, out_tok;

  // A beat is taken only when the queue can absorb two tokens.
  assign s_tready = room2;
  assign step     = s_tvalid && s_tready;

  clst_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .text_byte    (s_tdata),
    .end_of_input (s_tlast),
    .wr_n         (wr_n),
    .tok0         (tok0),
    .tok1         (tok1)
  );

  clst_tok_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_n     (wr_n),
    .wr_tok0  (tok0),
    .wr_tok1  (tok1),
    .room2    (room2),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_tok   (out_tok)
  );

  // Pack the token fields lowest first; pad the top to a whole byte.
  assign m_tdata = {3'b000, out_tok.c2, out_tok.c1, out_tok.len, out_tok.start, out_tok.kw};
  assign m_tuser = out_tok.cls;
  assign m_tlast = out_tok.last;

endmodule

@@ hdl/clst_kw_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clst_kw_match - keyword lookup
// Compares the held identifier against every keyword in parallel and returns
// the index of the one that matches.
// ----------------------------------------------------------------------------
module clst_kw_match (
  input  logic [clst_pkg::WORD_DEPTH-1:0][7:0] word,
  input  logic [clst_pkg::WORD_LEN_W-1:0]      word_len,
  input  logic                                 enable,
  output logic                                 hit,
  output logic [clst_pkg::KW_IDX_W-1:0]        index
);
  import clst_pkg::*;

  logic [8*WORD_DEPTH-1:0] packed_word;
  logic [8*WORD_DEPTH-1:0] justified;
  logic [6:0]              shamt;

  // First character in the top byte, then shift down so the word is
  // right-justified like the table; unwritten bytes fall off the bottom.
  always_comb begin
    for (int n = 0; n < WORD_DEPTH; n++) begin
      packed_word[8*(WORD_DEPTH-1-n) +: 8] = word[n];
    end
    shamt     = 7'((WORD_DEPTH - int'(word_len)) * 8);
    justified = packed_word >> shamt;
  end

  always_comb begin
    hit   = 1'b0;
    index = '0;
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      if (!hit && enable && KW_LEN[k] == word_len && KW_TEXT[k] == justified) begin
        hit   = 1'b1;
        index = KW_IDX_W'(k);
      end
    end
  end

endmodule

@@ hdl/clst_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clst_scan - byte scanner
// Holds the open token and turns one accepted byte into up to two tokens:
// one closed by the byte and one that the byte forms on its own.
// ----------------------------------------------------------------------------
module clst_scan #(
  parameter int POSITION_BITS = clst_pkg::POSITION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     text_byte,
  input  logic           end_of_input,
  output logic [1:0]     wr_n,
  output clst_pkg::tok_t tok0,
  output clst_pkg::tok_t tok1
);
  import clst_pkg::*;

  localparam int PB = POSITION_BITS;

  scan_mode_t                    mode, mode_next;
  logic [7:0]                    held_char, held_next;
  logic [PB-1:0]                 token_start, start_next;
  logic [PB-1:0]                 byte_count, count_next;
  logic [PB-1:0]                 run_length, run_next;
  logic                          word_overlong, overlong_next;
  logic [WORD_DEPTH-1:0][7:0]    word_store;
  logic                          we;
  logic [WORD_LEN_W-1:0]         wr_idx;
  logic                          kw_en, kw_hit;
  logic [KW_IDX_W-1:0]           kw_idx;
  logic                          a_v, b_v, restart;
  tok_t                          a_tok, b_tok, word_tok;
  logic [PB-1:0]                 run_inc;

  function automatic logic [15:0] lim16(input logic [PB-1:0] v);
    if (|(v >> 16)) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  assign kw_en = !word_overlong && (run_length <= PB'(WORD_DEPTH));

  clst_kw_match u_kw (
    .word     (word_store),
    .word_len (run_length[WORD_LEN_W-1:0]),
    .enable   (kw_en),
    .hit      (kw_hit),
    .index    (kw_idx)
  );

  assign run_inc  = sat_inc(run_length);
  assign word_tok = make_tok(kw_hit ? CLS_KEYWORD : CLS_IDENT, kw_hit ? kw_idx : '0,
                             lim16(token_start), lim16(run_length), held_char, 8'h00);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      held_char     <= '0;
      token_start   <= '0;
      byte_count    <= '0;
      run_length    <= '0;
      word_overlong <= 1'b0;
    end else if (step) begin
      mode          <= mode_next;
      held_char     <= held_next;
      token_start   <= start_next;
      byte_count    <= count_next;
      run_length    <= run_next;
      word_overlong <= overlong_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && we) begin
      word_store[wr_idx] <= text_byte;
    end
  end

  always_comb begin
    mode_next     = mode;
    held_next     = held_char;
    start_next    = token_start;
    count_next    = sat_inc(byte_count);
    run_next      = run_length;
    overlong_next = word_overlong;
    we            = 1'b0;
    wr_idx        = run_length[WORD_LEN_W-1:0];
    a_v           = 1'b0;
    a_tok         = word_tok;
    b_v           = 1'b0;
    b_tok         = make_tok(CLS_UNKNOWN, '0, lim16(byte_count), 16'd1, text_byte, 8'h00);
    restart       = 1'b0;

    if (end_of_input) begin
      // Flush the open token, report end, return to the reset state.
      unique case (mode)
        MODE_IDENT: begin
          a_v = 1'b1;
        end
        MODE_INT: begin
          a_v   = 1'b1;
          a_tok = make_tok(CLS_INTEGER, '0, lim16(token_start), lim16(run_length),
                           held_char, 8'h00);
        end
        MODE_SLASH: begin
          a_v   = 1'b1;
          a_tok = make_tok(CLS_OPERATOR, '0, lim16(token_start), 16'd1, held_char, 8'h00);
        end
        MODE_DIRECTIVE: begin
          a_v   = 1'b1;
          a_tok = make_tok(CLS_DIRECT, '0, lim16(token_start), lim16(run_length),
                           held_char, 8'h00);
        end
        MODE_REL: begin
          a_v   = 1'b1;
          a_tok = make_tok(CLS_REL, '0, lim16(token_start), 16'd1, held_char, 8'h00);
        end
        MODE_STRING: begin
          a_v   = 1'b1;
          a_tok = make_tok(CLS_STRING, '0, lim16(token_start), lim16(run_length),
                           held_char, 8'h00);
        end
        default: a_v = 1'b0;
      endcase
      b_v           = 1'b1;
      b_tok         = make_tok(CLS_END, '0, lim16(byte_count), 16'd0, 8'h00, 8'h00);
      mode_next     = MODE_IDLE;
      held_next     = '0;
      start_next    = '0;
      count_next    = '0;
      run_next      = '0;
      overlong_next = 1'b0;
    end else begin
      unique case (mode)
        MODE_IDENT: begin
          if (is_letter(text_byte)) begin
            if (run_length < PB'(WORD_DEPTH)) we = 1'b1;
            else overlong_next = 1'b1;
            run_next = run_inc;
          end else begin
            a_v     = 1'b1;
            restart = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit(text_byte)) begin
            run_next = run_inc;
          end else begin
            a_v     = 1'b1;
            a_tok   = make_tok(CLS_INTEGER, '0, lim16(token_start), lim16(run_length),
                               held_char, 8'h00);
            restart = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (text_byte == CH_SLASH) begin
            mode_next = MODE_COMMENT;
          end else begin
            a_v     = 1'b1;
            a_tok   = make_tok(CLS_OPERATOR, '0, lim16(token_start), 16'd1, held_char, 8'h00);
            restart = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (text_byte == CH_NL) mode_next = MODE_IDLE;
        end
        MODE_DIRECTIVE: begin
          if (text_byte == CH_NL) begin
            a_v       = 1'b1;
            a_tok     = make_tok(CLS_DIRECT, '0, lim16(token_start), lim16(run_length),
                                 held_char, 8'h00);
            mode_next = MODE_IDLE;
          end else begin
            run_next = run_inc;
          end
        end
        MODE_REL: begin
          a_v = 1'b1;
          if (rel_pair(held_char, text_byte)) begin
            a_tok     = make_tok(CLS_REL, '0, lim16(token_start), 16'd2, held_char, text_byte);
            mode_next = MODE_IDLE;
          end else begin
            a_tok   = make_tok(CLS_REL, '0, lim16(token_start), 16'd1, held_char, 8'h00);
            restart = 1'b1;
          end
        end
        MODE_STRING: begin
          run_next = run_inc;
          if (text_byte == CH_QUOTE) begin
            a_v       = 1'b1;
            a_tok     = make_tok(CLS_STRING, '0, lim16(token_start), lim16(run_inc),
                                 held_char, 8'h00);
            mode_next = MODE_IDLE;
          end
        end
        default: restart = 1'b1;
      endcase

      // Handle the byte on its own, as the first byte of a new token.
      if (restart) begin
        mode_next = MODE_IDLE;
        case (text_byte) inside
          CH_PLUS, CH_MINUS, CH_STAR, CH_PCT: begin
            b_v       = 1'b1;
            b_tok.cls = CLS_OPERATOR;
          end
          CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK, CH_SEMI, CH_LBRACE, CH_RBRACE: begin
            b_v       = 1'b1;
            b_tok.cls = CLS_SYMBOL;
          end
          CH_SLASH:                          mode_next = MODE_SLASH;
          CH_HASH:                           mode_next = MODE_DIRECTIVE;
          CH_LT, CH_GT, CH_EQ, CH_BANG, CH_BAR: mode_next = MODE_REL;
          CH_QUOTE:                          mode_next = MODE_STRING;
          CH_SPACE, CH_TAB, CH_NL:           mode_next = MODE_IDLE;
          default: begin
            if (is_letter(text_byte)) begin
              mode_next     = MODE_IDENT;
              we            = 1'b1;
              wr_idx        = '0;
              overlong_next = 1'b0;
            end else if (is_digit(text_byte)) begin
              mode_next = MODE_INT;
            end else begin
              b_v = 1'b1;
            end
          end
        endcase
        if (mode_next != MODE_IDLE) begin
          held_next  = text_byte;
          start_next = byte_count;
          run_next   = PB'(1);
        end
      end
    end
  end

  // Pack the tokens so the first one written is always in tok0; flag the last.
  always_comb begin
    tok0 = a_v ? a_tok : b_tok;
    tok1 = b_tok;
    tok0.last = !(a_v && b_v);
    tok1.last = 1'b1;
    wr_n = step ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
  end

endmodule

@@ hdl/clst_tok_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clst_tok_fifo - token queue
// Four-entry register queue taking up to two tokens per cycle and giving one.
// ----------------------------------------------------------------------------
module clst_tok_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     wr_n,
  input  clst_pkg::tok_t wr_tok0,
  input  clst_pkg::tok_t wr_tok1,
  output logic           room2,
  output logic           rd_valid,
  input  logic           rd_ready,
  output clst_pkg::tok_t rd_tok
);
  import clst_pkg::*;

  tok_t       entry [4];
  logic [1:0] head, tail;
  logic [2:0] count, count_next;
  logic       pop;

  assign room2    = (count <= 3'd2);
  assign rd_valid = (count != 3'd0);
  assign rd_tok   = entry[head];
  assign pop      = rd_valid && rd_ready;
  assign count_next = count + {1'b0, wr_n} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + {1'b0, pop};
      tail  <= tail + wr_n;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) entry[tail] <= wr_tok0;
    if (wr_n == 2'd2) entry[tail + 2'd1] <= wr_tok1;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking regression for the C-like source tokenizer
// Streams source text into the block one byte per beat, including end-of-input
// beats. A scanner model in the testbench predicts every token. Each token
// beat that leaves the block is checked field by field against it. Both sides
// idle at random. The token side holds off for long stretches. A final
// end-of-input beat closes the text once every earlier token is out.
// ----------------------------------------------------------------------------
module tb;
  import clst_pkg::*;

  // one queued input beat and the idle cycles the sender spends after it
  typedef struct {
    logic [7:0] data;
    logic       eoi;
    int         gap;
    logic       drain;   // wait for every outstanding token before this beat
  } text_beat_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;  // [7:0] text_byte
  logic        s_tlast  = 1'b0;   // end_of_input
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;           // [4:0] keyword_index, [20:5] start_position,
                                  // [36:21] token_length, [44:37] lead_char,
                                  // [52:45] second_char, [55:53] zero
  logic [3:0]  m_tuser;           // [3:0] token_class
  logic        m_tlast;           // last_of_run

  c_like_source_tokenizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // keyword list in table order; the token carries the position in this list
  string kw_words [KEYWORD_COUNT] = '{
    "int", "double", "float", "for", "while", "if", "else", "char", "bool",
    "break", "return", "private", "public", "protected", "new", "class",
    "struct", "true", "false", "switch", "case", "continue", "default",
    "virtual", "void", "enum"
  };

  text_beat_t source_bytes [$];    // beats still to be offered
  tok_t       pending_tokens [$];  // predicted tokens not yet seen
  tok_t       beat_toks [$];       // tokens formed by the beat being scanned

  logic src_burst  = 1'b0;         // queue beats with no idle cycles
  logic drain_next = 1'b0;

  // scanner model state
  scan_mode_t  lx_mode   = MODE_IDLE;
  logic [7:0]  held      = 8'h00;
  logic [15:0] tok_at    = 16'd0;
  logic [15:0] byte_pos  = 16'd0;
  logic [15:0] run_len   = 16'd0;
  logic [7:0]  word_buf [WORD_DEPTH];
  logic        word_long = 1'b0;

  int mismatches = 0;
  int in_beats   = 0;
  int eoi_beats  = 0;
  int tok_seen   = 0;
  int cls_seen [10];
  int src_gap    = 0;
  int rx_wait    = 0;
  int rx_taken   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // ------------------------------------------------------------------------
  // Scanner model
  // ------------------------------------------------------------------------
  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic letter_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // at most two tokens per beat; anything beyond that is dropped
  task put_tok(input tok_class_t cls, input logic [4:0] kw, input logic [15:0] at,
               input logic [15:0] len, input logic [7:0] c1, input logic [7:0] c2);
    tok_t t;
    t.cls   = cls;
    t.kw    = kw;
    t.start = at;
    t.len   = len;
    t.c1    = c1;
    t.c2    = c2;
    t.last  = 1'b0;
    if (beat_toks.size() < 2) beat_toks.insert(beat_toks.size(), t);
  endtask

  task open_tok(input scan_mode_t m, input logic [7:0] c, input logic [15:0] at);
    lx_mode = m;
    held    = c;
    tok_at  = at;
    run_len = 16'd1;
  endtask

  // close the open word: a keyword only if it fits the store and matches exactly
  task close_word;
    int   k;
    int   n;
    int   kw_hit;
    logic same;
    kw_hit = -1;
    if (!word_long && run_len <= WORD_DEPTH) begin
      for (k = 0; k < KEYWORD_COUNT; k++) begin
        if (kw_hit < 0 && kw_words[k].len() == int'(run_len)) begin
          same = 1'b1;
          for (n = 0; n < int'(run_len); n++)
            if (kw_words[k][n] != word_buf[n]) same = 1'b0;
          if (same) kw_hit = k;
        end
      end
    end
    if (kw_hit >= 0) put_tok(CLS_KEYWORD, 5'(kw_hit), tok_at, run_len, held, 8'h00);
    else put_tok(CLS_IDENT, 5'd0, tok_at, run_len, held, 8'h00);
  endtask

  // handle a byte with no token open
  task take_byte(input logic [7:0] c, input logic [15:0] at);
    lx_mode = MODE_IDLE;
    if (letter_byte(c)) begin
      open_tok(MODE_IDENT, c, at);
      word_buf[0] = c;
      word_long   = 1'b0;
    end else if (digit_byte(c)) begin
      open_tok(MODE_INT, c, at);
    end else begin
      case (c)
        CH_PLUS, CH_MINUS, CH_STAR, CH_PCT:
          put_tok(CLS_OPERATOR, 5'd0, at, 16'd1, c, 8'h00);
        CH_SLASH: open_tok(MODE_SLASH, c, at);
        CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK, CH_SEMI, CH_LBRACE, CH_RBRACE:
          put_tok(CLS_SYMBOL, 5'd0, at, 16'd1, c, 8'h00);
        CH_HASH: open_tok(MODE_DIRECTIVE, c, at);
        CH_LT, CH_GT, CH_EQ, CH_BANG, CH_BAR: open_tok(MODE_REL, c, at);
        CH_QUOTE: open_tok(MODE_STRING, c, at);
        CH_SPACE, CH_TAB, CH_NL: ;
        default: put_tok(CLS_UNKNOWN, 5'd0, at, 16'd1, c, 8'h00);
      endcase
    end
  endtask

  // scan one accepted beat and queue the tokens it completes
  task lex_beat(input logic [7:0] c, input logic eoi);
    logic [15:0] here;
    logic        paired;
    here = byte_pos;
    beat_toks.delete();
    if (eoi) begin
      // flush whatever is open, drop a comment, then report the end
      case (lx_mode)
        MODE_IDENT:     close_word();
        MODE_INT:       put_tok(CLS_INTEGER, 5'd0, tok_at, run_len, held, 8'h00);
        MODE_SLASH:     put_tok(CLS_OPERATOR, 5'd0, tok_at, 16'd1, held, 8'h00);
        MODE_DIRECTIVE: put_tok(CLS_DIRECT, 5'd0, tok_at, run_len, held, 8'h00);
        MODE_REL:       put_tok(CLS_REL, 5'd0, tok_at, 16'd1, held, 8'h00);
        MODE_STRING:    put_tok(CLS_STRING, 5'd0, tok_at, run_len, held, 8'h00);
        default: ;
      endcase
      put_tok(CLS_END, 5'd0, here, 16'd0, 8'h00, 8'h00);
      lx_mode   = MODE_IDLE;
      held      = 8'h00;
      tok_at    = 16'd0;
      byte_pos  = 16'd0;
      run_len   = 16'd0;
      word_long = 1'b0;
    end else begin
      case (lx_mode)
        MODE_IDENT: begin
          if (letter_byte(c)) begin
            if (run_len < WORD_DEPTH) word_buf[run_len] = c;
            else word_long = 1'b1;
            run_len = bump(run_len);
          end else begin
            close_word();
            take_byte(c, here);
          end
        end
        MODE_INT: begin
          if (digit_byte(c)) begin
            run_len = bump(run_len);
          end else begin
            put_tok(CLS_INTEGER, 5'd0, tok_at, run_len, held, 8'h00);
            take_byte(c, here);
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            lx_mode = MODE_COMMENT;
          end else begin
            put_tok(CLS_OPERATOR, 5'd0, tok_at, 16'd1, held, 8'h00);
            take_byte(c, here);
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NL) lx_mode = MODE_IDLE;
        end
        MODE_DIRECTIVE: begin
          if (c == CH_NL) begin
            put_tok(CLS_DIRECT, 5'd0, tok_at, run_len, held, 8'h00);
            lx_mode = MODE_IDLE;
          end else begin
            run_len = bump(run_len);
          end
        end
        MODE_REL: begin
          case (held)
            CH_EQ, CH_BANG: paired = (c == CH_EQ);
            CH_LT:          paired = (c == CH_LT) || (c == CH_EQ);
            CH_GT:          paired = (c == CH_GT) || (c == CH_EQ);
            CH_BAR:         paired = (c == CH_BAR);
            default:        paired = 1'b0;
          endcase
          if (paired) begin
            put_tok(CLS_REL, 5'd0, tok_at, 16'd2, held, c);
            lx_mode = MODE_IDLE;
          end else begin
            put_tok(CLS_REL, 5'd0, tok_at, 16'd1, held, 8'h00);
            take_byte(c, here);
          end
        end
        MODE_STRING: begin
          run_len = bump(run_len);
          if (c == CH_QUOTE) begin
            put_tok(CLS_STRING, 5'd0, tok_at, run_len, held, 8'h00);
            lx_mode = MODE_IDLE;
          end
        end
        default: take_byte(c, here);
      endcase
      byte_pos = bump(byte_pos);
    end
    if (beat_toks.size() != 0) beat_toks[beat_toks.size() - 1].last = 1'b1;
    foreach (beat_toks[i]) pending_tokens.insert(pending_tokens.size(), beat_toks[i]);
  endtask

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  task queue_byte(input logic [7:0] b, input logic eoi);
    text_beat_t t;
    t.data     = b;
    t.eoi      = eoi;
    t.gap      = src_burst ? 0 : $urandom_range(0, 5);
    t.drain    = drain_next;
    drain_next = 1'b0;
    source_bytes.insert(source_bytes.size(), t);
  endtask

  // random byte that is not the given terminator
  function automatic logic [7:0] body_byte(input logic [7:0] stop);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == stop) ? 8'h41 : b;
  endfunction

  function automatic logic [7:0] any_letter;
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return CH_UNDER;
  endfunction

  initial begin
    string      seed_text;
    int         kind;
    int         n;
    int         k;
    int         kw_next;
    logic       mid_drain;
    logic [7:0] b;

    // directed opening: keyword, comment, directive, paired relationals,
    // string, comma as unidentified, both byte extremes, then end of input
    seed_text = "int//\n#a\n<<||\"s\",";
    for (n = 0; n < seed_text.len(); n++) queue_byte(seed_text[n], 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);

    // random source text: mostly well-formed fragments, some noise
    drain_next = 1'b1;
    kw_next    = 0;
    mid_drain  = 1'b0;
    while (source_bytes.size() < 450) begin
      src_burst = (source_bytes.size() >= 300 && source_bytes.size() < 360);
      if (!mid_drain && source_bytes.size() >= 250) begin
        drain_next = 1'b1;
        mid_drain  = 1'b1;
      end
      kind = $urandom_range(0, 15);
      case (kind)
        0, 1: begin
          // walk the whole keyword list first, then pick at random
          k = (kw_next < KEYWORD_COUNT) ? kw_next : $urandom_range(0, KEYWORD_COUNT - 1);
          kw_next++;
          for (n = 0; n < kw_words[k].len(); n++) queue_byte(kw_words[k][n], 1'b0);
          if ($urandom_range(0, 3) == 0) queue_byte(any_letter(), 1'b0);
        end
        2, 3: begin
          k = $urandom_range(1, 12);
          for (n = 0; n < k; n++) queue_byte(any_letter(), 1'b0);
        end
        4: begin
          k = $urandom_range(1, 5);
          for (n = 0; n < k; n++) queue_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
        end
        5: begin
          case ($urandom_range(0, 4))
            0: b = CH_PLUS;
            1: b = CH_MINUS;
            2: b = CH_STAR;
            3: b = CH_PCT;
            default: b = CH_SLASH;
          endcase
          queue_byte(b, 1'b0);
        end
        6: begin
          queue_byte(CH_SLASH, 1'b0);
          queue_byte(CH_SLASH, 1'b0);
          k = $urandom_range(0, 5);
          for (n = 0; n < k; n++) queue_byte(body_byte(CH_NL), 1'b0);
          queue_byte(CH_NL, 1'b0);
        end
        7: begin
          case ($urandom_range(0, 6))
            0: b = CH_LPAR;
            1: b = CH_RPAR;
            2: b = CH_LBRK;
            3: b = CH_RBRK;
            4: b = CH_LBRACE;
            5: b = CH_RBRACE;
            default: b = CH_SEMI;
          endcase
          queue_byte(b, 1'b0);
        end
        8: begin
          queue_byte(CH_HASH, 1'b0);
          k = $urandom_range(0, 5);
          for (n = 0; n < k; n++) queue_byte(body_byte(CH_NL), 1'b0);
          if ($urandom_range(0, 7) != 0) queue_byte(CH_NL, 1'b0);
        end
        9, 10: begin
          case ($urandom_range(0, 4))
            0: b = CH_EQ;
            1: b = CH_BANG;
            2: b = CH_LT;
            3: b = CH_GT;
            default: b = CH_BAR;
          endcase
          queue_byte(b, 1'b0);
          case ($urandom_range(0, 5))
            0: queue_byte(CH_EQ, 1'b0);
            1: queue_byte(CH_LT, 1'b0);
            2: queue_byte(CH_GT, 1'b0);
            3: queue_byte(CH_BAR, 1'b0);
            4: queue_byte(8'($urandom_range(0, 255)), 1'b0);
            default: ;
          endcase
        end
        11: begin
          queue_byte(CH_QUOTE, 1'b0);
          k = $urandom_range(0, 5);
          for (n = 0; n < k; n++) queue_byte(body_byte(CH_QUOTE), 1'b0);
          if ($urandom_range(0, 5) != 0) queue_byte(CH_QUOTE, 1'b0);
        end
        12: begin
          case ($urandom_range(0, 2))
            0: queue_byte(CH_SPACE, 1'b0);
            1: queue_byte(CH_TAB, 1'b0);
            default: queue_byte(CH_NL, 1'b0);
          endcase
        end
        13: queue_byte(8'($urandom_range(0, 255)), 1'b0);
        14: begin
          if ($urandom_range(0, 2) == 0) queue_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        default: ;
      endcase
      if ($urandom_range(0, 1) == 0) queue_byte(CH_SPACE, 1'b0);
    end

    // close the text once every earlier token is out
    src_burst  = 1'b0;
    drain_next = 1'b1;
    queue_byte(8'h00, 1'b1);

    // wait for the last beat to go in and every token to come out
    @(posedge clk);
    while (rst || source_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d byte beats and %0d end-of-input beats; %0d tokens checked",
             in_beats, eoi_beats, tok_seen);
    $display("per class kw id int op sym dir rel str unk end: %0d %0d %0d %0d %0d",
             cls_seen[0], cls_seen[1], cls_seen[2], cls_seen[3], cls_seen[4]);
    $display("  ... %0d %0d %0d %0d %0d",
             cls_seen[5], cls_seen[6], cls_seen[7], cls_seen[8], cls_seen[9]);
    if (mismatches == 0) begin
      $display("c_like_source_tokenizer regression: pass");
    end else begin
      $display("c_like_source_tokenizer regression: fail");
    end
    $finish;
  end

  // give up well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("c_like_source_tokenizer regression: fail");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Driver: offer queued beats, idle between them, hold a draining beat back
  // until nothing is outstanding (only checked while the bus is quiet, so the
  // monitor has already logged every earlier beat)
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    text_beat_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else if (!s_tvalid || s_tready) begin
      if (src_gap != 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (source_bytes.size() != 0 &&
                   (!source_bytes[0].drain || (!s_tvalid && pending_tokens.size() == 0))) begin
        nxt = source_bytes.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.data;
        s_tlast  <= nxt.eoi;
        src_gap = nxt.gap;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Token receiver: random back-pressure per token, a calm window with none,
  // and two long hold-offs so the block's token queue fills and stalls input
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        rx_taken++;
        if (rx_taken == 40 || rx_taken == 150) rx_wait = 60;
        else if (rx_taken >= 90 && rx_taken < 130) rx_wait = 0;
        else rx_wait = $urandom_range(0, 5);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0);
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: predict on every accepted byte beat, check every token beat
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    tok_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (s_tlast) eoi_beats++;
        else in_beats++;
        lex_beat(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        tok_seen++;
        if (m_tuser < 4'd10) cls_seen[m_tuser]++;
        if (pending_tokens.size() == 0) begin
          $error("unexpected token: class %0d start %0d", m_tuser, m_tdata[20:5]);
          mismatches++;
        end else begin
          want = pending_tokens.pop_front();
          if (m_tuser !== want.cls) begin
            $error("token_class: expected %0d, got %0d", want.cls, m_tuser);
            mismatches++;
          end
          if (m_tdata[4:0] !== want.kw) begin
            $error("keyword_index: expected %0d, got %0d", want.kw, m_tdata[4:0]);
            mismatches++;
          end
          if (m_tdata[20:5] !== want.start) begin
            $error("start_position: expected %0d, got %0d", want.start, m_tdata[20:5]);
            mismatches++;
          end
          if (m_tdata[36:21] !== want.len) begin
            $error("token_length: expected %0d, got %0d", want.len, m_tdata[36:21]);
            mismatches++;
          end
          if (m_tdata[44:37] !== want.c1) begin
            $error("lead_char: expected %0d, got %0d", want.c1, m_tdata[44:37]);
            mismatches++;
          end
          if (m_tdata[52:45] !== want.c2) begin
            $error("second_char: expected %0d, got %0d", want.c2, m_tdata[52:45]);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
            mismatches++;
          end
        end
      end
    end
  end

endmodule
